// ===== rtl/sensor_frame_crc_decoder_unit_defines.svh =====
// assertion macros for the sensor frame crc decoder
// used by the top level only; expects clk and arst_n in scope
`ifndef SENSOR_FRAME_CRC_DECODER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_CRC_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SFCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define SFCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sfcd_pkg.sv =====
// shared constants, types and the crc-8 step for the sensor frame decoder
// no dependencies; used by sfcd_frame and sensor_frame_crc_decoder_unit
package sfcd_pkg;

	// crc-8, msb first, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// byte positions within a frame (0 means no frame open)
	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
	localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
	localparam logic [POS_W-1:0] POS_HUM_LAST = 3'd2;
	localparam logic [POS_W-1:0] POS_SPLIT = 3'd3;
	localparam logic [POS_W-1:0] POS_CRC   = 3'd6;

	// reading widths
	localparam int unsigned RAW_W  = 20;
	localparam int unsigned HUM_W  = 14;
	localparam int unsigned TC_W   = 15;
	localparam int unsigned TF_W   = 16;
	localparam int unsigned DATA_W = 96;

	// scale factors: full scale times 100, applied as raw * k >> 20
	localparam logic [13:0] HUM_SCALE = 14'd10000;
	localparam logic [14:0] TC_SCALE  = 15'd20000;
	localparam logic [15:0] TF_SCALE  = 16'd36000;
	localparam logic signed [15:0] TC_OFFSET = 16'sd5000;
	localparam logic signed [16:0] TF_OFFSET = 17'sd5800;

	// a completed frame as handed to the conversion stage
	typedef struct packed {
		logic             ok;
		logic [7:0]       status;
		logic [RAW_W-1:0] humidity_raw;
		logic [RAW_W-1:0] temperature_raw;
	} frame_t;

	// one byte through the crc-8 register
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/sfcd_frame.sv =====
// frame tracker: byte position, running crc and raw value assembly
// depends on sfcd_pkg
module sfcd_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      rx_byte,
	input  logic            frame_start,
	output logic            frame_done,
	output sfcd_pkg::frame_t frame
);
	import sfcd_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       crc_q, crc_d;
	logic [7:0]       status_q, status_d;
	logic [RAW_W-1:0] hum_q, hum_d;
	logic [RAW_W-1:0] temp_q, temp_d;
	logic             crc_match;

	// next state of the frame for the byte in hand
	always_comb begin
		pos_d      = pos_q;
		crc_d      = crc_q;
		status_d   = status_q;
		hum_d      = hum_q;
		temp_d     = temp_q;
		frame_done = 1'b0;
		if (frame_start) begin
			status_d = rx_byte;
			crc_d    = crc8_feed(CRC_INIT, rx_byte);
			hum_d    = '0;
			temp_d   = '0;
			pos_d    = POS_FIRST;
		end else if (pos_q == POS_IDLE) begin
			// byte outside a frame is dropped
			pos_d = POS_IDLE;
		end else if (pos_q < POS_CRC) begin
			crc_d = crc8_feed(crc_q, rx_byte);
			if (pos_q <= POS_HUM_LAST) begin
				hum_d = {hum_q[RAW_W-9:0], rx_byte};
			end else if (pos_q == POS_SPLIT) begin
				hum_d  = {hum_q[RAW_W-5:0], rx_byte[7:4]};
				temp_d = {{(RAW_W-4){1'b0}}, rx_byte[3:0]};
			end else begin
				temp_d = {temp_q[RAW_W-9:0], rx_byte};
			end
			pos_d = pos_q + POS_FIRST;
		end else begin
			// crc byte closes the frame
			frame_done = 1'b1;
			pos_d      = POS_IDLE;
			crc_d      = CRC_INIT;
		end
	end

	// frame contents, zeroed on a crc mismatch
	assign crc_match = (rx_byte == crc_q);
	always_comb begin
		frame.ok              = crc_match;
		frame.status          = crc_match ? status_q : '0;
		frame.humidity_raw    = crc_match ? hum_q : '0;
		frame.temperature_raw = crc_match ? temp_q : '0;
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_IDLE;
			crc_q    <= CRC_INIT;
			status_q <= '0;
			hum_q    <= '0;
			temp_q   <= '0;
		end else if (advance) begin
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			status_q <= status_d;
			hum_q    <= hum_d;
			temp_q   <= temp_d;
		end
	end

endmodule

// ===== rtl/sensor_frame_crc_decoder_unit.sv =====
// channel  | dir | tdata fields (low bit up)                          | tuser
// s_       | in  | rx_byte[7:0]                                       | frame_start
// m_       | out | status_byte, humidity_raw, temperature_raw,        | crc_ok
//          |     | humidity_centi, temp_c_centi, temp_f_centi, pad    |
//
// one byte per cycle sustained while the stages are not full behind a stalled result
// stages: input register, frame tracker into frame register, scaling into result register
// arst_n clears all valid flags and the frame state (no frame open, crc 0xFF)
// a stalled result holds the pipeline only once every stage before it is full
//
// top level of the sensor frame crc decoder
// depends on sfcd_pkg, sfcd_frame and sensor_frame_crc_decoder_unit_defines.svh
`include "sensor_frame_crc_decoder_unit_defines.svh"

module sensor_frame_crc_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
	input  logic                        s_tuser,  // [0] frame_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] status_byte, [27:8] humidity_raw, [47:28] temperature_raw,
	// [61:48] humidity_centi, [76:62] temp_c_centi, [92:77] temp_f_centi, [95:93] zero
	output logic [sfcd_pkg::DATA_W-1:0] m_tdata,
	output logic                        m_tuser   // [0] crc_ok
);
	import sfcd_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             valid_s2;
	frame_t           frame_s2;
	logic             s2_free;
	logic             out_adv;
	logic             advance;
	logic             frame_done;
	frame_t           frame;

	logic [33:0]      hum_prod;
	logic [34:0]      tc_prod;
	logic [35:0]      tf_prod;
	logic signed [15:0] tc_val;
	logic signed [16:0] tf_val;

	logic             m_valid_q;
	logic             ok_q;
	logic [7:0]       status_q;
	logic [RAW_W-1:0] hum_raw_q;
	logic [RAW_W-1:0] temp_raw_q;
	logic [HUM_W-1:0] hum_centi_q;
	logic signed [TC_W-1:0] tc_centi_q;
	logic signed [TF_W-1:0] tf_centi_q;

	// stage flow control
	assign out_adv  = !m_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_adv;
	assign s_tready = !valid_s1 || s2_free;
	assign advance  = valid_s1 && s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// frame tracker
	sfcd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.frame_done (frame_done),
		.frame      (frame)
	);

	// completed frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance && frame_done;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && advance && frame_done) begin
			frame_s2 <= frame;
		end
	end

	// scaling to hundredths, truncated before the offset
	always_comb begin
		hum_prod = 34'(frame_s2.humidity_raw) * 34'(HUM_SCALE);
		tc_prod  = 35'(frame_s2.temperature_raw) * 35'(TC_SCALE);
		tf_prod  = 36'(frame_s2.temperature_raw) * 36'(TF_SCALE);
		tc_val   = $signed({1'b0, tc_prod[34:20]}) - TC_OFFSET;
		tf_val   = $signed({1'b0, tf_prod[35:20]}) - TF_OFFSET;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			ok_q       <= frame_s2.ok;
			status_q   <= frame_s2.status;
			hum_raw_q  <= frame_s2.humidity_raw;
			temp_raw_q <= frame_s2.temperature_raw;
			if (frame_s2.ok) begin
				hum_centi_q <= hum_prod[33:20];
				tc_centi_q  <= tc_val[TC_W-1:0];
				tf_centi_q  <= tf_val[TF_W-1:0];
			end else begin
				hum_centi_q <= '0;
				tc_centi_q  <= '0;
				tf_centi_q  <= '0;
			end
		end
	end

	// output packing
	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {3'b000, tf_centi_q, tc_centi_q, hum_centi_q, temp_raw_q, hum_raw_q,
		status_q};

	// checks
	`SFCD_ASSERT_SAME(a_bad_crc_zero, m_valid_q && !ok_q, m_tdata == '0, "crc mismatch result not cleared")
	`SFCD_ASSERT_SAME(a_hum_range, m_valid_q, hum_centi_q < HUM_SCALE, "humidity above full scale")
	`SFCD_ASSERT_NEXT(a_no_phantom, out_adv && !valid_s2, !m_valid_q, "result without a frame")

endmodule

// ===== verif/tb_top.sv =====
// self-checking bench for sensor_frame_crc_decoder_unit: byte stream in, decoded readings out
// depends on sfcd_pkg and the rtl; predicts each reading and checks every result transfer
// the sender bursts with random gaps and the receiver stalls on its own pattern
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ITEM_TARGET  = 1700;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 20;
	localparam logic [19:0] RAW_MAX      = 20'hFFFFF;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  status;
		logic [19:0] hum_raw;
		logic [19:0] temp_raw;
		logic [13:0] hum_centi;
		logic [14:0] tc_centi;
		logic [15:0] tf_centi;
	} reading_t;

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata  = 8'h00;
	logic                        s_tuser  = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [sfcd_pkg::DATA_W-1:0] m_tdata;
	logic                        m_tuser;

	rx_item_t pending_bytes[$];
	reading_t expected_readings[$];
	int       fail_count = 0;
	int       frame_items = 0;

	// predicted decoder state, starts at its reset values
	logic [2:0]  frame_pos  = sfcd_pkg::POS_IDLE;
	logic [7:0]  crc_run    = sfcd_pkg::CRC_INIT;
	logic [7:0]  status_run = 8'h00;
	logic [19:0] hum_run    = '0;
	logic [19:0] temp_run   = '0;

	// sender and receiver pacing
	logic        byte_taken  = 1'b0;
	int          burst_left  = 1;
	int          gap_left    = 0;
	int          ready_left  = 0;
	bit          ready_phase = 1'b0;
	rx_item_t    next_item;

	sensor_frame_crc_decoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// one byte through crc-8, msb first
	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ sfcd_pkg::CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	// raw reading biased towards the ends of the range
	function automatic logic [19:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return RAW_MAX;
			2: return 20'($urandom_range(0, 15));
			3: return RAW_MAX - 20'($urandom_range(0, 15));
			default: return 20'($urandom_range(0, RAW_MAX));
		endcase
	endfunction

	// builds a reply frame; keep < 7 leaves it unfinished, crc_flip corrupts the crc byte
	task automatic queue_frame(input logic [7:0] status, input logic [19:0] hum,
			input logic [19:0] temp, input logic [7:0] crc_flip, input int keep);
		logic [7:0] frame_bytes[7];
		logic [7:0] acc;
		frame_bytes[0] = status;
		frame_bytes[1] = hum[19:12];
		frame_bytes[2] = hum[11:4];
		frame_bytes[3] = {hum[3:0], temp[19:16]};
		frame_bytes[4] = temp[15:8];
		frame_bytes[5] = temp[7:0];
		acc = sfcd_pkg::CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			acc = crc8_next(acc, frame_bytes[i]);
		end
		frame_bytes[6] = acc ^ crc_flip;
		for (int i = 0; i < keep; i++) begin
			pending_bytes.push_back(rx_item_t'{rx_byte: frame_bytes[i], frame_start: (i == 0)});
		end
		frame_items += keep;
	endtask

	task automatic queue_stray();
		pending_bytes.push_back(rx_item_t'{rx_byte: 8'($urandom_range(0, 255)), frame_start: 1'b0});
	endtask

	// advance the predicted frame state by one accepted byte
	task automatic predict_byte(input logic [7:0] b, input logic start);
		reading_t        r;
		longint unsigned hr;
		longint unsigned tr;
		int              tc;
		int              tf;
		if (start) begin
			status_run = b;
			crc_run    = crc8_next(sfcd_pkg::CRC_INIT, b);
			hum_run    = '0;
			temp_run   = '0;
			frame_pos  = sfcd_pkg::POS_FIRST;
		end else if (frame_pos != sfcd_pkg::POS_IDLE) begin
			if (frame_pos < sfcd_pkg::POS_CRC) begin
				crc_run = crc8_next(crc_run, b);
				if (frame_pos <= sfcd_pkg::POS_HUM_LAST) begin
					hum_run = {hum_run[11:0], b};
				end else if (frame_pos == sfcd_pkg::POS_SPLIT) begin
					hum_run  = {hum_run[15:0], b[7:4]};
					temp_run = {16'd0, b[3:0]};
				end else begin
					temp_run = {temp_run[11:0], b};
				end
				frame_pos = frame_pos + 3'd1;
			end else begin
				// crc byte: one reading, all zero including the flag on mismatch
				r = '0;
				if (b == crc_run) begin
					hr          = hum_run;
					tr          = temp_run;
					tc          = int'((tr * 20000) >> 20) - 5000;
					tf          = int'((tr * 36000) >> 20) - 5800;
					r.ok        = 1'b1;
					r.status    = status_run;
					r.hum_raw   = hum_run;
					r.temp_raw  = temp_run;
					r.hum_centi = 14'((hr * 10000) >> 20);
					r.tc_centi  = tc[14:0];
					r.tf_centi  = tf[15:0];
				end
				expected_readings.push_back(r);
				frame_pos = sfcd_pkg::POS_IDLE;
				crc_run   = sfcd_pkg::CRC_INIT;
			end
		end
	endtask

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endfunction

	// compare one result transfer with the oldest predicted reading
	task automatic check_reading();
		reading_t r;
		if (expected_readings.size() == 0) begin
			$error("result transfer with no reading expected: tuser %0b tdata 0x%h", m_tuser, m_tdata);
			fail_count++;
		end else begin
			r = expected_readings.pop_front();
			compare_field("crc_ok", r.ok, m_tuser);
			compare_field("status_byte", r.status, m_tdata[7:0]);
			compare_field("humidity_raw", r.hum_raw, m_tdata[27:8]);
			compare_field("temperature_raw", r.temp_raw, m_tdata[47:28]);
			compare_field("humidity_centi", r.hum_centi, m_tdata[61:48]);
			compare_field("temp_c_centi", r.tc_centi, m_tdata[76:62]);
			compare_field("temp_f_centi", r.tf_centi, m_tdata[92:77]);
			compare_field("pad", 32'd0, m_tdata[95:93]);
		end
	endtask

	// monitor: both sides sampled at the rising edge
	always @(posedge clk) begin
		byte_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			predict_byte(s_tdata, s_tuser);
		end
		if (m_tvalid && m_tready) begin
			check_reading();
		end
	end

	// driver: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				next_item = pending_bytes.pop_front();
				s_tdata  <= next_item.rx_byte;
				s_tuser  <= next_item.frame_start;
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: alternating ready and stall runs, now and then a long ready stretch
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_phase = !ready_phase;
			if (ready_phase) begin
				ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
			end else begin
				ready_left = $urandom_range(1, 10);
			end
		end
		ready_left--;
		m_tready <= ready_phase;
	end

	// watchdog
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int sel;
		// directed: stray byte with no frame open
		pending_bytes.push_back(rx_item_t'{rx_byte: 8'hFF, frame_start: 1'b0});
		// frame dropped after three bytes by the next start flag
		queue_frame(8'h1C, 20'h12345, 20'h6789A, 8'h00, 3);
		// all-ones and all-zero frames with good crc
		queue_frame(8'hFF, RAW_MAX, RAW_MAX, 8'h00, 7);
		queue_frame(8'h00, 20'h00000, 20'h00000, 8'h00, 7);
		// crc mismatch with busy bit set
		queue_frame(8'h80, 20'h80000, 20'h7FFFF, 8'h01, 7);

		// random: mostly well-formed frames, then corrupt, cut short and stray bytes
		while (frame_items < ITEM_TARGET) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				queue_frame(8'($urandom_range(0, 255)), pick_raw(), pick_raw(), 8'h00, 7);
			end else if (sel < 82) begin
				queue_frame(8'($urandom_range(0, 255)), pick_raw(), pick_raw(),
					8'($urandom_range(1, 255)), 7);
			end else if (sel < 92) begin
				queue_frame(8'($urandom_range(0, 255)), pick_raw(), pick_raw(), 8'h00,
					$urandom_range(1, 6));
			end else begin
				repeat ($urandom_range(1, 4)) queue_stray();
			end
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every byte to be taken and every reading to come out
		while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_readings.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfcd_pkg.sv
rtl/sfcd_frame.sv
rtl/sensor_frame_crc_decoder_unit.sv
verif/tb_top.sv
